FILE: design/cron_calendar_minute_matcher_top_defines.svh
// Assertion macros shared by the matcher's queue and back modules.
`ifndef CRON_CALENDAR_MINUTE_MATCHER_TOP_DEFINES_SVH
`define CRON_CALENDAR_MINUTE_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define CCMM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCMM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ccmm_pkg.sv
package ccmm_pkg;

  localparam int QDEPTH       = 8;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int FRONT_STAGES = 5;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MONTH_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY_MASK = 3'd4;

  localparam logic [13:0] YEAR_MIN  = 14'd1970;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [13:0] YEAR_TOP  = 14'h3fff;
  // floor(y/100) = (y * 10486) >> 20 for y < 16384
  localparam logic [13:0] Q100_MUL  = 14'd10486;
  localparam int          Q100_SH   = 20;
  // floor(t/7) = (t * 74899) >> 19 for t < 16384
  localparam logic [16:0] Q7_MUL    = 17'd74899;
  localparam int          Q7_SH     = 19;
  // leap days up to 1969, less the +4 Thursday offset, plus the -1 of the day
  localparam logic [13:0] WD_BIAS   = 14'd474;

  localparam logic [13:0] RST_YEAR    = 14'd1970;
  localparam logic [6:0]  RST_YMOD100 = 7'd70;
  localparam logic [1:0]  RST_C4      = 2'd3;
  localparam logic [2:0]  RST_WEEKDAY = 3'd4;

  typedef struct packed {
    logic        func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic [6:0]  ymod100;  // year mod 100
    logic [1:0]  c4;       // (year / 100) mod 4
  } item_t;

  typedef struct packed {
    logic        matched;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } result_t;

  function automatic logic is_leap(input logic [1:0] ylow, input logic [6:0] ymod100,
                                   input logic [1:0] c4);
    is_leap = (ylow == 2'd0) && ((ymod100 != 7'd0) || (c4 == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m) inside
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd2:    month_start = 9'd31;
      4'd3:    month_start = 9'd59;
      4'd4:    month_start = 9'd90;
      4'd5:    month_start = 9'd120;
      4'd6:    month_start = 9'd151;
      4'd7:    month_start = 9'd181;
      4'd8:    month_start = 9'd212;
      4'd9:    month_start = 9'd243;
      4'd10:   month_start = 9'd273;
      4'd11:   month_start = 9'd304;
      4'd12:   month_start = 9'd334;
      default: month_start = 9'd0;
    endcase
  endfunction

endpackage

FILE: design/ccmm_front.sv
module ccmm_front
  import ccmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_func,
  input  logic [13:0]       in_load_year,
  input  logic [3:0]        in_load_month,
  input  logic [4:0]        in_load_day,
  input  logic [4:0]        in_load_hour,
  input  logic [5:0]        in_load_minute,
  input  logic [QAW:0]      q_count,
  output logic              q_push,
  output item_t             q_item
);

  localparam int CW = QAW + 2;

  typedef struct packed {
    logic        func;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  q100;
    logic [6:0]  ymod100;
    logic [1:0]  c4;
    logic        leap;
    logic [13:0] tsum;
    logic [11:0] q7;
  } stage_t;

  stage_t                  st_r   [FRONT_STAGES];
  stage_t                  st_nxt [FRONT_STAGES];
  logic [FRONT_STAGES-1:0] v_r;
  logic                    accept;
  logic [CW-1:0]           reserved;
  logic [27:0]             prod100;
  logic [30:0]             prod7;
  logic [4:0]              dlen;
  logic [6:0]              ymod_c;
  logic                    leap_c;
  logic [13:0]             yprev;
  logic [13:0]             leaps;
  logic [14:0]             q7x7;

  // slots already promised to the queue: held entries plus beats in flight
  assign reserved = CW'(q_count) + CW'($countones(v_r));
  assign full     = reserved >= CW'(QDEPTH);
  assign accept   = push && !full;

  assign prod100 = 28'(st_r[0].year) * 28'(Q100_MUL);
  assign ymod_c  = 7'(st_r[1].year - 14'(st_r[1].q100) * 14'd100);
  assign leap_c  = is_leap(st_r[1].year[1:0], ymod_c, st_r[1].q100[1:0]);
  assign dlen    = month_len(st_r[1].month, leap_c);
  assign yprev   = st_r[2].year - 14'd1;
  assign leaps   = 14'(yprev[13:2]) - 14'(st_r[2].q100) + 14'(st_r[2].q100[6:2]);
  assign prod7   = 31'(st_r[3].tsum) * 31'(Q7_MUL);
  assign q7x7    = {st_r[4].q7, 3'b000} - 15'(st_r[4].q7);

  always_comb begin
    st_nxt[0] = '0;
    for (int i = 1; i < FRONT_STAGES; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    // stage 1: clamp the loaded fields other than day
    st_nxt[0].func   = in_func;
    st_nxt[0].year   = (in_load_year < YEAR_MIN) ? YEAR_MIN :
                       (in_load_year > YEAR_MAX) ? YEAR_MAX : in_load_year;
    st_nxt[0].month  = (in_load_month == 4'd0) ? 4'd1 :
                       (in_load_month > 4'd12) ? 4'd12 : in_load_month;
    st_nxt[0].day    = in_load_day;
    st_nxt[0].hour   = (in_load_hour > 5'd23) ? 5'd23 : in_load_hour;
    st_nxt[0].minute = (in_load_minute > 6'd59) ? 6'd59 : in_load_minute;

    // stage 2: century
    st_nxt[1].q100 = 7'(prod100[27:Q100_SH]);

    // stage 3: leap, day clamp; q100 becomes floor((year-1)/100)
    st_nxt[2].ymod100 = ymod_c;
    st_nxt[2].c4      = st_r[1].q100[1:0];
    st_nxt[2].leap    = leap_c;
    st_nxt[2].day     = (st_r[1].day == 5'd0) ? 5'd1 :
                        (st_r[1].day > dlen) ? dlen : st_r[1].day;
    st_nxt[2].q100    = st_r[1].q100 - 7'(ymod_c == 7'd0);

    // stage 4: day count, congruent mod 7 (365 = 1 mod 7)
    st_nxt[3].tsum = (st_r[2].year - YEAR_MIN) + leaps - WD_BIAS
                     + 14'(month_start(st_r[2].month))
                     + 14'(st_r[2].leap && (st_r[2].month > 4'd2))
                     + 14'(st_r[2].day);

    // stage 5: quotient by 7
    st_nxt[4].q7 = 12'(prod7[30:Q7_SH]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-2:0], accept};
    end
    for (int i = 0; i < FRONT_STAGES; i++) begin
      st_r[i] <= st_nxt[i];
    end
  end

  assign q_push         = v_r[FRONT_STAGES-1];
  assign q_item.func    = st_r[4].func;
  assign q_item.year    = st_r[4].year;
  assign q_item.month   = st_r[4].month;
  assign q_item.day     = st_r[4].day;
  assign q_item.hour    = st_r[4].hour;
  assign q_item.minute  = st_r[4].minute;
  assign q_item.weekday = 3'(15'(st_r[4].tsum) - q7x7);
  assign q_item.ymod100 = st_r[4].ymod100;
  assign q_item.c4      = st_r[4].c4;

endmodule

FILE: design/ccmm_queue.sv
module ccmm_queue
  import ccmm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  item_t        din,
  input  logic         pop,
  output item_t        dout,
  output logic         empty,
  output logic [QAW:0] count
);

`include "cron_calendar_minute_matcher_top_defines.svh"

  localparam logic [QAW:0] FULL_CNT = (QAW+1)'(QDEPTH);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  `CCMM_ASSERT_IMP(a_q_no_overflow, push, count_r != FULL_CNT, "queue written while full")
  `CCMM_ASSERT_IMP(a_q_count_max, 1'b1, count_r <= FULL_CNT, "queue count past depth")
  `CCMM_ASSERT_NXT(a_q_beat_lands, push && !pop, count_r != '0, "pushed beat not held")

endmodule

FILE: design/ccmm_back.sv
module ccmm_back
  import ccmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_empty,
  input  item_t                 q_item,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output result_t               res
);

`include "cron_calendar_minute_matcher_top_defines.svh"

  logic [59:0] minute_mask_r;
  logic [23:0] hour_mask_r;
  logic [31:0] day_mask_r;
  logic [12:0] month_mask_r;
  logic [6:0]  weekday_mask_r;

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic [6:0]  ymod100_r, ymod100_nxt;
  logic [1:0]  c4_r, c4_nxt;

  result_t     rb_r [2];
  logic        rb_wr_r;
  logic        rb_rd_r;
  logic [1:0]  rb_cnt_r;
  logic        take;
  logic        out_pop;
  logic        is_tick;
  result_t     res_nxt;

  assign out_pop = pop && (rb_cnt_r != 2'd0);
  assign take    = !q_empty && ((rb_cnt_r != 2'd2) || out_pop);
  assign is_tick = (q_item.func == FUNC_TICK);

  always_comb begin
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    weekday_nxt = weekday_r;
    ymod100_nxt = ymod100_r;
    c4_nxt      = c4_r;

    res_nxt.matched = 1'b0;
    res_nxt.year    = year_r;
    res_nxt.month   = month_r;
    res_nxt.day     = day_r;
    res_nxt.hour    = hour_r;
    res_nxt.minute  = minute_r;
    res_nxt.weekday = weekday_r;

    if (is_tick) begin
      res_nxt.matched = minute_mask_r[minute_r] && hour_mask_r[hour_r] &&
                        day_mask_r[day_r] && month_mask_r[month_r] &&
                        weekday_mask_r[weekday_r];
      if (minute_r >= 6'd59) begin
        minute_nxt = 6'd0;
        if (hour_r >= 5'd23) begin
          hour_nxt    = 5'd0;
          weekday_nxt = (weekday_r >= 3'd6) ? 3'd0 : weekday_r + 3'd1;
          if (day_r >= month_len(month_r, is_leap(year_r[1:0], ymod100_r, c4_r))) begin
            day_nxt = 5'd1;
            if (month_r >= 4'd12) begin
              month_nxt = 4'd1;
              if (year_r == YEAR_TOP) begin
                // wrap to year 0: a leap year, century 0
                year_nxt    = 14'd0;
                ymod100_nxt = 7'd0;
                c4_nxt      = 2'd0;
              end else begin
                year_nxt    = year_r + 14'd1;
                ymod100_nxt = (ymod100_r == 7'd99) ? 7'd0 : ymod100_r + 7'd1;
                c4_nxt      = c4_r + 2'(ymod100_r == 7'd99);
              end
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            day_nxt = day_r + 5'd1;
          end
        end else begin
          hour_nxt = hour_r + 5'd1;
        end
      end else begin
        minute_nxt = minute_r + 6'd1;
      end
    end else begin
      year_nxt        = q_item.year;
      month_nxt       = q_item.month;
      day_nxt         = q_item.day;
      hour_nxt        = q_item.hour;
      minute_nxt      = q_item.minute;
      weekday_nxt     = q_item.weekday;
      ymod100_nxt     = q_item.ymod100;
      c4_nxt          = q_item.c4;
      res_nxt.year    = q_item.year;
      res_nxt.month   = q_item.month;
      res_nxt.day     = q_item.day;
      res_nxt.hour    = q_item.hour;
      res_nxt.minute  = q_item.minute;
      res_nxt.weekday = q_item.weekday;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_mask_r  <= '0;
      hour_mask_r    <= '0;
      day_mask_r     <= '0;
      month_mask_r   <= '0;
      weekday_mask_r <= '0;
      year_r         <= RST_YEAR;
      month_r        <= 4'd1;
      day_r          <= 5'd1;
      hour_r         <= 5'd0;
      minute_r       <= 6'd0;
      weekday_r      <= RST_WEEKDAY;
      ymod100_r      <= RST_YMOD100;
      c4_r           <= RST_C4;
      rb_wr_r        <= 1'b0;
      rb_rd_r        <= 1'b0;
      rb_cnt_r       <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MINUTE_MASK:  minute_mask_r  <= cfg_data[59:0];
          CFG_HOUR_MASK:    hour_mask_r    <= cfg_data[23:0];
          CFG_DAY_MASK:     day_mask_r     <= cfg_data[31:0];
          CFG_MONTH_MASK:   month_mask_r   <= cfg_data[12:0];
          CFG_WEEKDAY_MASK: weekday_mask_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (take) begin
        year_r    <= year_nxt;
        month_r   <= month_nxt;
        day_r     <= day_nxt;
        hour_r    <= hour_nxt;
        minute_r  <= minute_nxt;
        weekday_r <= weekday_nxt;
        ymod100_r <= ymod100_nxt;
        c4_r      <= c4_nxt;
        rb_wr_r   <= ~rb_wr_r;
      end
      if (out_pop) begin
        rb_rd_r <= ~rb_rd_r;
      end
      rb_cnt_r <= rb_cnt_r + 2'(take) - 2'(out_pop);
    end
    if (take) begin
      rb_r[rb_wr_r] <= res_nxt;
    end
  end

  assign q_pop = take;
  assign empty = (rb_cnt_r == 2'd0);
  assign res   = rb_r[rb_rd_r];

  `CCMM_ASSERT_IMP(a_b_time_range, 1'b1, minute_r <= 6'd59 && hour_r <= 5'd23, "clock out of range")
  `CCMM_ASSERT_NXT(a_b_minute_step, take && is_tick && minute_r != 6'd59, minute_r == 6'($past(minute_r) + 6'd1), "tick did not advance minute")
  `CCMM_ASSERT_IMP(a_b_rb_bound, 1'b1, rb_cnt_r <= 2'd2, "result buffer overrun")

endmodule

FILE: design/cron_calendar_minute_matcher_top.sv
// Cron schedule matcher on a minute-resolution calendar clock. A load beat
// (in_func 0) sets the clock from the clamped load fields and returns it with
// out_matched 0; a tick beat (in_func 1) returns the current minute with its
// match against the five masks, then advances the clock one minute. One beat
// is accepted per cycle while full is low, and one result leaves per cycle
// while pop is held and empty is low. Each beat first passes a 5-stage
// front pipeline (clamping, century by reciprocal multiply, leap year and
// day clamp, day count, mod-7 by reciprocal multiply for the weekday), then
// an 8-entry queue, then the clock register stage, which applies one beat
// per cycle into a 2-entry result buffer while that buffer has room. full
// rises when the queue plus the beats in the front pipeline reach 8.
// Write the cfg_ masks only with no beats outstanding.
module cron_calendar_minute_matcher_top
  import ccmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_func,
  input  logic [13:0]           in_load_year,
  input  logic [3:0]            in_load_month,
  input  logic [4:0]            in_load_day,
  input  logic [4:0]            in_load_hour,
  input  logic [5:0]            in_load_minute,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_matched,
  output logic [13:0]           out_year,
  output logic [3:0]            out_month,
  output logic [4:0]            out_day,
  output logic [4:0]            out_hour,
  output logic [5:0]            out_minute,
  output logic [2:0]            out_weekday
);

  logic         q_push;
  logic         q_pop;
  logic         q_empty;
  logic [QAW:0] q_count;
  item_t        q_in;
  item_t        q_out;
  result_t      res;

  ccmm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .in_load_hour   (in_load_hour),
    .in_load_minute (in_load_minute),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  ccmm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty),
    .count (q_count)
  );

  ccmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_matched = res.matched;
  assign out_year    = res.year;
  assign out_month   = res.month;
  assign out_day     = res.day;
  assign out_hour    = res.hour;
  assign out_minute  = res.minute;
  assign out_weekday = res.weekday;

endmodule

FILE: test/calendar_match_checker.sv
`timescale 1ns / 1ps
module calendar_match_checker
  import ccmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic                  full,
  input  logic                  in_func,
  input  logic [13:0]           in_load_year,
  input  logic [3:0]            in_load_month,
  input  logic [4:0]            in_load_day,
  input  logic [4:0]            in_load_hour,
  input  logic [5:0]            in_load_minute,
  input  logic                  empty,
  input  logic                  pop,
  input  logic                  out_matched,
  input  logic [13:0]           out_year,
  input  logic [3:0]            out_month,
  input  logic [4:0]            out_day,
  input  logic [4:0]            out_hour,
  input  logic [5:0]            out_minute,
  input  logic [2:0]            out_weekday,
  output int                    mismatches,
  output int                    outstanding
);

  // schedule masks as last written
  logic [59:0] minute_sel;
  logic [23:0] hour_sel;
  logic [31:0] day_sel;
  logic [12:0] month_sel;
  logic [6:0]  weekday_sel;

  // predicted calendar clock
  logic [13:0] now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_day;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;
  logic [2:0]  now_weekday;

  result_t awaited_minutes[$];
  int      errs = 0;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      2:           n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic int unsigned leap_count(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // days since 1970-01-01 (a Thursday), folded to a weekday
  function automatic logic [2:0] weekday_of_date(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
    int unsigned days;
    days = 365 * (y - 1970) + leap_count(y - 1) - leap_count(1969) + d - 1;
    for (int unsigned k = 1; k < m; k++) days += month_days(y, k);
    return 3'((days + 4) % 7);
  endfunction

  // report for one beat and apply it to the predicted clock: a load is applied before its report, a tick after
  function automatic result_t calendar_step(input logic func, input logic [13:0] y_in,
                                            input logic [3:0] m_in, input logic [4:0] d_in,
                                            input logic [4:0] h_in, input logic [5:0] mi_in);
    result_t     r;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned dl;
    r = '0;
    if (func == FUNC_LOAD) begin
      y = y_in;
      m = m_in;
      d = d_in;
      if (y < 1970) y = 1970;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      dl = month_days(y, m);
      if (d < 1) d = 1;
      if (d > dl) d = dl;
      now_year    = 14'(y);
      now_month   = 4'(m);
      now_day     = 5'(d);
      now_hour    = (h_in > 23) ? 5'd23 : h_in;
      now_minute  = (mi_in > 59) ? 6'd59 : mi_in;
      now_weekday = weekday_of_date(y, m, d);
    end else begin
      r.matched = minute_sel[now_minute] & hour_sel[now_hour] & day_sel[now_day] &
                  month_sel[now_month] & weekday_sel[now_weekday];
    end
    r.year    = now_year;
    r.month   = now_month;
    r.day     = now_day;
    r.hour    = now_hour;
    r.minute  = now_minute;
    r.weekday = now_weekday;
    if (func == FUNC_TICK) begin
      if (now_minute == 59) begin
        now_minute = 0;
        if (now_hour == 23) begin
          now_hour    = 0;
          now_weekday = (now_weekday == 6) ? 3'd0 : now_weekday + 3'd1;
          if (now_day == month_days(now_year, now_month)) begin
            now_day = 1;
            if (now_month == 12) begin
              now_month = 1;
              now_year  = now_year + 14'd1;  // 14-bit wrap
            end else begin
              now_month = now_month + 4'd1;
            end
          end else begin
            now_day = now_day + 5'd1;
          end
        end else begin
          now_hour = now_hour + 5'd1;
        end
      end else begin
        now_minute = now_minute + 6'd1;
      end
    end
    return r;
  endfunction

  function automatic string show_minute(input result_t r);
    return $sformatf("m=%0d %0d-%0d-%0d %0d:%0d wd=%0d", r.matched, r.year, r.month, r.day,
                     r.hour, r.minute, r.weekday);
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      minute_sel  = '0;
      hour_sel    = '0;
      day_sel     = '0;
      month_sel   = '0;
      weekday_sel = '0;
      now_year    = 14'd1970;
      now_month   = 4'd1;
      now_day     = 5'd1;
      now_hour    = 5'd0;
      now_minute  = 6'd0;
      now_weekday = 3'd4;
      awaited_minutes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MINUTE_MASK:  minute_sel  = cfg_data[59:0];
          CFG_HOUR_MASK:    hour_sel    = cfg_data[23:0];
          CFG_DAY_MASK:     day_sel     = cfg_data[31:0];
          CFG_MONTH_MASK:   month_sel   = cfg_data[12:0];
          CFG_WEEKDAY_MASK: weekday_sel = cfg_data[6:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        seen = '{matched: out_matched, year: out_year, month: out_month, day: out_day,
                 hour: out_hour, minute: out_minute, weekday: out_weekday};
        if (awaited_minutes.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result beat: %s", show_minute(seen));
        end else begin
          want = awaited_minutes.pop_front();
          if (seen !== want) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected %s, got %s", show_minute(want), show_minute(seen));
          end
        end
      end
      if (push && !full)
        awaited_minutes.insert(awaited_minutes.size(),
                               calendar_step(in_func, in_load_year, in_load_month,
                                             in_load_day, in_load_hour, in_load_minute));
    end
    mismatches  <= errs;
    outstanding <= awaited_minutes.size();
  end

endmodule

FILE: test/cron_calendar_minute_matcher_top_tb.sv
`timescale 1ns / 1ps
module cron_calendar_minute_matcher_top_tb;
  import ccmm_pkg::*;

  localparam int MASK_MIXED  = -1;
  localparam int MASK_ONES   = 0;
  localparam int MASK_ZERO   = 1;
  localparam int MASK_RANDOM = 2;
  localparam int MASK_DENSE  = 3;

  localparam logic [CFG_IDX_W-1:0] MASK_REGS [5] = '{CFG_MINUTE_MASK, CFG_HOUR_MASK,
                                                     CFG_DAY_MASK, CFG_MONTH_MASK,
                                                     CFG_WEEKDAY_MASK};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  in_func = FUNC_LOAD;
  logic [13:0]           in_load_year = '0;
  logic [3:0]            in_load_month = '0;
  logic [4:0]            in_load_day = '0;
  logic [4:0]            in_load_hour = '0;
  logic [5:0]            in_load_minute = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  out_matched;
  logic [13:0]           out_year;
  logic [3:0]            out_month;
  logic [4:0]            out_day;
  logic [4:0]            out_hour;
  logic [5:0]            out_minute;
  logic [2:0]            out_weekday;

  int   mismatches;
  int   outstanding;
  logic calm = 1'b0;      // no idling on either side
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   stall_left = 0;

  cron_calendar_minute_matcher_top uut (.*);

  calendar_match_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      pop        <= 1'b0;
      stall_left <= 120;
      hold_done  <= 1'b1;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  function automatic logic [59:0] pick_mask(input int style);
    logic [59:0] m;
    case (style)
      MASK_ONES:   m = '1;
      MASK_ZERO:   m = '0;
      MASK_RANDOM: m = 60'({$urandom, $urandom});
      default:     m = ~(60'({$urandom, $urandom}) & 60'({$urandom, $urandom}) &
                         60'({$urandom, $urandom}));
    endcase
    return m;
  endfunction

  task automatic program_masks(input int style);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= MASK_REGS[i];
      cfg_data  <= pick_mask((style == MASK_MIXED) ? int'($urandom_range(0, 3)) : style);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // let every expected result come back, then a margin past the pipeline depth
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_beat(input logic func, input logic [13:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [4:0] h, input logic [5:0] mi);
    while (!calm && $urandom_range(0, 99) < 6) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_func        <= func;
    in_load_year   <= y;
    in_load_month  <= m;
    in_load_day    <= d;
    in_load_hour   <= h;
    in_load_minute <= mi;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // load fields carry junk on a tick beat
  task automatic send_tick();
    send_beat(FUNC_TICK, 14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
              6'($urandom));
  endtask

  task automatic send_random_load();
    logic [13:0] y;
    if ($urandom_range(0, 3) == 0) begin
      send_tick_free_load: begin
        send_beat(FUNC_LOAD, 14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                  6'($urandom));
      end
    end else begin
      case ($urandom_range(0, 7))
        0:       y = 14'd2000;
        1:       y = 14'd2100;
        2:       y = 14'd2400;
        3:       y = 14'd9999;
        default: y = 14'($urandom_range(1970, 9999));
      endcase
      // near the end of hour, day and month so that ticks carry
      send_beat(FUNC_LOAD, y, 4'($urandom_range(1, 12)), 5'($urandom_range(26, 31)),
                5'($urandom_range(21, 23)), 6'($urandom_range(50, 59)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_masks(MASK_ONES);
    send_tick();                                         // clock as left by reset
    send_beat(FUNC_LOAD, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0); // year, month and day clamped up
    send_beat(FUNC_LOAD, 14'h3fff, 4'hf, 5'h1f, 5'h1f, 6'h3f);
    send_tick();
    send_tick();                                         // past year 9999
    send_beat(FUNC_LOAD, 14'd2000, 4'd2, 5'd31, 5'd23, 6'd59);
    send_tick();
    send_tick();
    send_beat(FUNC_LOAD, 14'd2100, 4'd2, 5'd29, 5'd23, 6'd59);
    send_tick();
    send_tick();
    send_beat(FUNC_LOAD, 14'd2024, 4'd2, 5'd28, 5'd23, 6'd59);
    send_tick();
    send_tick();
    send_tick();
    send_beat(FUNC_LOAD, 14'd2023, 4'd4, 5'd31, 5'd23, 6'd59);
    send_tick();
    send_tick();
    send_beat(FUNC_LOAD, 14'd2023, 4'd6, 5'd15, 5'd10, 6'd59);
    send_tick();
    send_tick();
    send_beat(FUNC_LOAD, 14'd1969, 4'd0, 5'd0, 5'd24, 6'd60);
    send_tick();
    send_tick();
    push <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0:       program_masks(MASK_MIXED);
        1:       program_masks(MASK_DENSE);
        2:       program_masks(MASK_ZERO);
        3:       program_masks(MASK_MIXED);
        default: program_masks(MASK_ONES);
      endcase
      calm     <= (p == 1);
      hold_req <= (p == 3);
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(0, 9) == 0) send_random_load();
        else send_tick();
      end
      push <= 1'b0;
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
